[rtl/core/srr_pkg.sv]
// Shared types and constants for the selective-repeat receive window.
// Used by srr_ram, srr_engine and selective_repeat_receive_reorder.
package srr_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int WSIZE_W   = 6;
  localparam logic [WSIZE_W-1:0] WSIZE_RST = 6'd8;
  localparam int SEQ_W     = 32;
  localparam int PAY_W     = 32;

  typedef enum logic [1:0] {
    KIND_REJECT  = 2'd0,
    KIND_STORE   = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  pay;
    logic              last;
  } res_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[rtl/core/srr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on srr_pkg for the address width helper.
module srr_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = srr_pkg::DEPTH_DEF,
  parameter int AW    = srr_pkg::addr_w(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/srr_engine.sv]
// Window sequencer: clearing pass, insert, and in-order drain over the slot RAM.
// Depends on srr_pkg and srr_ram.
module srr_engine #(
  parameter int DEPTH = srr_pkg::DEPTH_DEF,
  parameter int AW    = srr_pkg::addr_w(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [srr_pkg::WSIZE_W-1:0]  win_size,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srr_pkg::SEQ_W-1:0]    seq_num,
  input  logic [srr_pkg::PAY_W-1:0]    payload,
  input  logic                         out_free,
  output logic                         res_load,
  output srr_pkg::res_t                res
);
  import srr_pkg::*;

  localparam int MW = PAY_W + 1;
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

  state_t state, state_next;
  logic [AW-1:0]    clr_addr;
  logic [SEQ_W-1:0] base;
  logic [AW-1:0]    head;
  kind_t            pend_kind;
  logic [SEQ_W-1:0] pend_seq;
  logic [PAY_W-1:0] pend_pay;
  logic             fwd;
  logic [MW-1:0]    fwd_data;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [MW-1:0] wr_data, rd_data;

  logic [SEQ_W-1:0] offset;
  logic             in_win;
  logic [AW:0]      slot_sum;
  logic [AW-1:0]    phys;
  logic [AW-1:0]    head_inc;
  logic [MW-1:0]    hd;
  logic             hv;
  logic             accept;

  srr_ram #(.WIDTH(MW), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    offset   = seq_num - base;
    in_win   = (offset < SEQ_W'(DEPTH)) && (offset < SEQ_W'(win_size));
    slot_sum = {1'b0, head} + {1'b0, offset[AW-1:0]};
    phys     = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : slot_sum[AW-1:0];
    head_inc = (head == LAST_IX) ? '0 : head + 1'b1;
    hd       = fwd ? fwd_data : rd_data;
    hv       = hd[MW-1];
    accept   = (state == ST_IDLE) && in_valid && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_IX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_win) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_free && !hv) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    wr_en    = 1'b0;
    wr_addr  = head;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = head;
    res_load = 1'b0;
    res      = '{kind: KIND_REJECT, seq: seq_num, pay: '0, last: 1'b1};
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      ST_IDLE: begin
        in_stall = !out_free;
        if (accept) begin
          if (in_win) begin
            wr_en   = 1'b1;
            wr_addr = phys;
            wr_data = {1'b1, payload};
            rd_en   = 1'b1;
          end else begin
            res_load = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          res_load = 1'b1;
          res      = '{kind: pend_kind, seq: pend_seq, pay: pend_pay, last: !hv};
          if (hv) begin
            wr_en   = 1'b1;
            rd_en   = 1'b1;
            rd_addr = head_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      base     <= '0;
      head     <= '0;
      fwd      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (rd_en) begin
        fwd      <= wr_en && (wr_addr == rd_addr);
        fwd_data <= wr_data;
      end
      if (state == ST_DRAIN && out_free && hv) begin
        base <= base + 1'b1;
        head <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_win) begin
      pend_kind <= KIND_STORE;
      pend_seq  <= seq_num;
      pend_pay  <= '0;
    end else if (state == ST_DRAIN && out_free && hv) begin
      pend_kind <= KIND_DELIVER;
      pend_seq  <= base;
      pend_pay  <= hd[PAY_W-1:0];
    end
  end

endmodule

[rtl/core/selective_repeat_receive_reorder.sv]
// Top level of the selective-repeat receive window: config register, output register.
// Depends on srr_pkg and srr_engine (which holds the slot RAM).
//
// Usage:
//  - Input channel in_valid/in_stall carries one packet beat: seq_num and payload.
//  - Output channel out_valid/out_stall carries result beats: kind, out_seq,
//    out_payload, last. last marks the final beat caused by one packet.
//  - Config channel cfg_valid/cfg_ready writes the window size (6 bits);
//    cfg_ready is always high. Write it only while the block is idle.
//  - A packet outside the window yields one reject beat, loaded into the output
//    register at the accept edge.
//  - A packet inside the window is written to the slot RAM and the head slot is
//    read in the same cycle; the store beat is loaded from the drain state, then
//    one deliver beat per cycle while the head slot is valid and the receiver
//    does not stall. The registered RAM read of the head slot sets the per-beat
//    pace of the drain.
//  - Each result beat is held in the pend registers so that its last flag can
//    see whether the next head slot is valid.
//  - Reset: a clearing pass writes every slot invalid, one entry per cycle;
//    in_stall stays high meanwhile. Base resets to 0 and the window size to 8.
//  - When the receiver stalls, the output register holds and the engine pauses;
//    no new packet is accepted until the current one is fully delivered.
module selective_repeat_receive_reorder #(
  parameter int WINDOW_DEPTH = srr_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srr_pkg::SEQ_W-1:0]    seq_num,
  input  logic [srr_pkg::PAY_W-1:0]    payload,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   kind,
  output logic [srr_pkg::SEQ_W-1:0]    out_seq,
  output logic [srr_pkg::PAY_W-1:0]    out_payload,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [srr_pkg::WSIZE_W-1:0]  cfg_data
);
  import srr_pkg::*;

  logic [WSIZE_W-1:0] win_size;
  logic               out_free;
  logic               res_load;
  res_t               res;

  // Config register: always ready, take every write beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= WSIZE_RST;
    end else if (cfg_valid) begin
      win_size <= cfg_data;
    end
  end

  // The output register is free when empty or when its beat leaves this edge.
  assign out_free = !out_valid || !out_stall;

  srr_engine #(.DEPTH(WINDOW_DEPTH)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .win_size    (win_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .seq_num     (seq_num),
    .payload     (payload),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  // Output register: load a new beat, or drop the valid once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      kind        <= res.kind;
      out_seq     <= res.seq;
      out_payload <= res.pay;
      last        <= res.last;
    end
  end

  // The engine never overwrites a beat that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded while output register busy");

  // A reject beat always closes its packet.
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_REJECT) |-> last)
    else $error("reject beat without last");

  // Only deliver beats carry a payload.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_DELIVER) |-> (out_payload == '0))
    else $error("nonzero payload on non-deliver beat");

  // An in-window packet blocks the input until its beats are produced.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (res_load && !res.last) |=> in_stall)
    else $error("input accepted while a packet is still draining");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for selective_repeat_receive_reorder.
// Depends on srr_pkg and the RTL under rtl/core; a scoreboard class predicts
// every result beat from the accepted packets and the window register.
module tb_top;
  import srr_pkg::*;

  // Quiet-cycle limit: set well above the long receiver hold, the clearing pass
  // after reset and the random stalls.
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_ITEMS  = 45;
  localparam int SETTLE       = 8;
  localparam int SB_AW        = addr_w(DEPTH_DEF);

  // Scoreboard: its own copy of the receive window, a queue of due beats.
  class window_scoreboard;
    logic [SEQ_W-1:0]   head_seq;
    bit                 held [DEPTH_DEF];
    logic [PAY_W-1:0]   held_pay [DEPTH_DEF];
    logic [WSIZE_W-1:0] wsize;
    res_t               beats_due [$];
    int                 errors;

    function new();
      head_seq = '0;
      wsize    = WSIZE_RST;
      errors   = 0;
      foreach (held[i]) begin
        held[i]     = 1'b0;
        held_pay[i] = '0;
      end
    endfunction

    function void set_window(logic [WSIZE_W-1:0] v);
      wsize = v;
    endfunction

    // Window sizes above the slot count saturate.
    function int span();
      return (wsize > DEPTH_DEF) ? DEPTH_DEF : int'(wsize);
    endfunction

    // Work out every beat one accepted packet causes and queue them in order.
    function void take_packet(logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] pay);
      logic [SEQ_W-1:0] offset;
      res_t             beat;
      offset = seq - head_seq;
      if (offset >= span()) begin
        beat = '{kind: KIND_REJECT, seq: seq, pay: '0, last: 1'b1};
        beats_due = {beats_due, beat};
        return;
      end
      held[offset[SB_AW-1:0]]     = 1'b1;
      held_pay[offset[SB_AW-1:0]] = pay;
      beat = '{kind: KIND_STORE, seq: seq, pay: '0, last: 1'b0};
      while (held[0]) begin
        beats_due = {beats_due, beat};
        beat = '{kind: KIND_DELIVER, seq: head_seq, pay: held_pay[0], last: 1'b0};
        head_seq = head_seq + 1'b1;
        for (int i = 0; i < DEPTH_DEF - 1; i++) begin
          held[i]     = held[i+1];
          held_pay[i] = held_pay[i+1];
        end
        held[DEPTH_DEF-1]     = 1'b0;
        held_pay[DEPTH_DEF-1] = '0;
      end
      beat.last = 1'b1;
      beats_due = {beats_due, beat};
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task match_beat(logic [1:0] k, logic [SEQ_W-1:0] s, logic [PAY_W-1:0] p,
                    logic l);
      res_t want;
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d seq %h", k, s));
        return;
      end
      want = beats_due.pop_front();
      if (k !== want.kind)
        report_mismatch($sformatf("seq %h: kind %0d, want %0d", want.seq, k, want.kind));
      if (s !== want.seq)
        report_mismatch($sformatf("seq %h, want %h", s, want.seq));
      if (p !== want.pay)
        report_mismatch($sformatf("seq %h: payload %h, want %h", want.seq, p, want.pay));
      if (l !== want.last)
        report_mismatch($sformatf("seq %h: last %b, want %b", want.seq, l, want.last));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [SEQ_W-1:0]    seq_num;
  logic [PAY_W-1:0]    payload;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          kind;
  logic [SEQ_W-1:0]    out_seq;
  logic [PAY_W-1:0]    out_payload;
  logic                last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WSIZE_W-1:0]  cfg_data;

  window_scoreboard    sb;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  int                  packets_sent;
  int                  quiet_cycles;
  int                  hold_left;
  bit                  hold_request;

  selective_repeat_receive_reorder uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .seq_num     (seq_num),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .out_seq     (out_seq),
    .out_payload (out_payload),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: pick the stall for the next edge at the falling edge. A hold
  // request from the sender keeps the output stalled until hold_left runs out,
  // so the block fills up and has to stall its input.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Check every result beat taken at a rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.match_beat(kind, out_seq, out_payload, last);
  end

  // Watchdog: end the run after too many cycles with no beat moving anywhere.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one packet beat; gaps come before it at the sender's idle rate.
  // Called and returns at a falling edge; valid stays up for the next call.
  task automatic send_packet(logic [SEQ_W-1:0] s, logic [PAY_W-1:0] p);
    bit taken;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    seq_num  <= s;
    payload  <= p;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    sb.take_packet(s, p);
    packets_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every due beat has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.beats_due.size() != 0)
      @(negedge clk);
  endtask

  // Write the window size only while the block is idle.
  task automatic write_window(logic [WSIZE_W-1:0] v);
    bit taken;
    drain_results();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
    end
    sb.set_window(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Out-of-window noise: a random number, one just behind the base, or one
  // just past the top of the window.
  task automatic send_noise();
    logic [SEQ_W-1:0] s;
    case ($urandom_range(0, 2))
      0: s = $urandom;
      1: s = sb.head_seq - $urandom_range(1, 64);
      default: s = sb.head_seq + sb.span() + $urandom_range(0, 8);
    endcase
    send_packet(s, $urandom);
  endtask

  // One random phase: rounds that fill a stretch of the window in shuffled
  // order, mixed with duplicates and noise, each round ending fully drained.
  task automatic run_phase(int tx_pct, int rx_pct, logic [WSIZE_W-1:0] wsz,
                           bit full_first, bit with_hold);
    int               order [DEPTH_DEF];
    int               count;
    int               pick;
    int               tmp;
    int               start_sent;
    bit               first;
    bit               hold_done;
    logic [SEQ_W-1:0] round_base;
    write_window(wsz);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_sent  = packets_sent;
    first       = 1'b1;
    hold_done   = 1'b0;
    while (packets_sent - start_sent < PHASE_ITEMS) begin
      round_base = sb.head_seq;
      if (first && full_first)
        count = sb.span();
      else
        count = $urandom_range(1, $urandom_range(1, sb.span()));
      for (int i = 0; i < count; i++)
        order[i] = i;
      for (int i = count - 1; i > 0; i--) begin
        pick     = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[pick];
        order[pick] = tmp;
      end
      // A full round with the base slot last drains the whole window at once.
      if (first && full_first) begin
        for (int i = 0; i < count; i++) begin
          if (order[i] == 0) begin
            order[i]         = order[count-1];
            order[count-1]   = 0;
          end
        end
      end
      for (int i = 0; i < count; i++) begin
        if (with_hold && !hold_done && packets_sent - start_sent >= 10) begin
          hold_request = 1'b1;
          hold_done    = 1'b1;
        end
        if ($urandom_range(0, 99) < 15)
          send_noise();
        if (i > 0 && $urandom_range(0, 99) < 10)
          send_packet(round_base + order[$urandom_range(0, i - 1)], $urandom);
        send_packet(round_base + order[i], $urandom);
      end
      first = 1'b0;
    end
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    seq_num      = '0;
    payload      = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    tx_idle_pct  = 28;
    rx_idle_pct  = 59;
    packets_sent = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    hold_request = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset window of 8, base at 0.
    send_packet(32'd0, 32'h0000_0000);          // in order: store and deliver
    send_packet(32'hFFFF_FFFF, $urandom);       // behind the base, wraps far out
    send_packet(32'd3, 32'hFFFF_FFFF);          // held out of order
    send_packet(32'd8, 32'h1234_5678);          // top of the window
    send_packet(32'd9, 32'h0BAD_0BAD);          // one past the top
    send_packet(32'd3, 32'hA5A5_5A5A);          // duplicate overwrites
    send_packet(32'd2, 32'h5A5A_A5A5);
    send_packet(32'd1, 32'h0000_0001);          // fills the gap, drains 1..3
    send_packet(32'd1, $urandom);               // already delivered
    send_packet(32'd7, $urandom);
    send_packet(32'd5, $urandom);
    send_packet(32'd6, $urandom);
    send_packet(32'd4, $urandom);               // drains 4..8

    // Window of zero rejects everything, even the base.
    write_window('0);
    send_packet(32'd9, $urandom);
    send_packet(32'h8000_0000, $urandom);

    // Hold two slots, then shrink the window under them.
    write_window(6'd8);
    send_packet(32'd14, $urandom);
    send_packet(32'd15, $urandom);
    write_window(6'd1);
    send_packet(32'd10, $urandom);              // now outside
    send_packet(32'd9, $urandom);
    send_packet(32'd10, $urandom);
    send_packet(32'd11, $urandom);
    send_packet(32'd12, $urandom);
    send_packet(32'd13, $urandom);              // held slots drain after it

    // Random phases: oversize window that saturates, a mid size, full depth.
    run_phase(28, 59, '1, 1'b1, 1'b0);
    run_phase(59, 28, 6'($urandom_range(2, 31)), 1'b0, 1'b0);
    run_phase(0, 0, 6'(DEPTH_DEF), 1'b1, 1'b1);

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/srr_pkg.sv
rtl/core/srr_ram.sv
rtl/core/srr_engine.sv
rtl/core/selective_repeat_receive_reorder.sv
dv/tb_top.sv
